// ----- rtl/ycc420_pkg.sv -----
// Shared types and constants for the 2x2 RGB to YCbCr 4:2:0 converter.
package ycc420_pkg;

   localparam int FRAC_BITS_DEFAULT = 14;
   localparam int PIXEL_COUNT       = 4;
   localparam int SAMPLE_W          = 8;
   localparam int CSR_ADDR_W        = 2;
   localparam int CSR_DATA_W        = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_CHROMA_MODE_ADDR = CSR_ADDR_W'(0);

   typedef enum logic [1:0] {
      CHROMA_ZERO     = 2'd0,
      CHROMA_TOP_LEFT = 2'd1,
      CHROMA_MEAN     = 2'd2,
      CHROMA_ZERO_ALT = 2'd3
   } chroma_mode_type;

   typedef logic [PIXEL_COUNT-1:0][SAMPLE_W-1:0] sample_set_type;

   typedef struct packed {
      logic prod_en;
      logic sum_en;
   } lane_ctrl_type;

endpackage

// ----- rtl/ycc420_lane.sv -----
// One pixel lane: registered coefficient products, then registered Y, Cb and Cr sums.
module ycc420_lane import ycc420_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  lane_ctrl_type       ctrl,
   input  logic [SAMPLE_W-1:0] red,
   input  logic [SAMPLE_W-1:0] green,
   input  logic [SAMPLE_W-1:0] blue,
   output logic [SAMPLE_W-1:0] luma,
   output logic [SAMPLE_W-1:0] cb,
   output logic [SAMPLE_W-1:0] cr
);

   localparam int ACC_W = FRAC_BITS + SAMPLE_W;

   localparam logic [ACC_W-1:0] COEF_Y_R  = ACC_W'(((257 << FRAC_BITS) + 500) / 1000);
   localparam logic [ACC_W-1:0] COEF_Y_G  = ACC_W'(((504 << FRAC_BITS) + 500) / 1000);
   localparam logic [ACC_W-1:0] COEF_Y_B  = ACC_W'(((98 << FRAC_BITS) + 500) / 1000);
   localparam logic [ACC_W-1:0] COEF_CB_R = ACC_W'(((148 << FRAC_BITS) + 500) / 1000);
   localparam logic [ACC_W-1:0] COEF_CB_G = ACC_W'(((291 << FRAC_BITS) + 500) / 1000);
   localparam logic [ACC_W-1:0] COEF_C_X  = ACC_W'(((439 << FRAC_BITS) + 500) / 1000);
   localparam logic [ACC_W-1:0] COEF_CR_G = ACC_W'(((368 << FRAC_BITS) + 500) / 1000);
   localparam logic [ACC_W-1:0] COEF_CR_B = ACC_W'(((71 << FRAC_BITS) + 500) / 1000);

   localparam logic [ACC_W-1:0] BIAS_Y = ACC_W'(16 << FRAC_BITS);
   localparam logic [ACC_W-1:0] BIAS_C = ACC_W'(128 << FRAC_BITS);
   localparam logic [ACC_W-1:0] HALF   = ACC_W'(1 << (FRAC_BITS - 1));

   logic [ACC_W-1:0] y_r_ff, y_g_ff, y_b_ff;
   logic [ACC_W-1:0] cb_r_ff, cb_g_ff, cb_b_ff;
   logic [ACC_W-1:0] cr_r_ff, cr_g_ff, cr_b_ff;
   logic [ACC_W-1:0] y_sum_in, cb_sum_in, cr_sum_in;
   logic [SAMPLE_W-1:0] luma_ff, cb_ff, cr_ff;

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         y_r_ff  <= COEF_Y_R  * ACC_W'(red);
         y_g_ff  <= COEF_Y_G  * ACC_W'(green);
         y_b_ff  <= COEF_Y_B  * ACC_W'(blue);
         cb_r_ff <= COEF_CB_R * ACC_W'(red);
         cb_g_ff <= COEF_CB_G * ACC_W'(green);
         cb_b_ff <= COEF_C_X  * ACC_W'(blue);
         cr_r_ff <= COEF_C_X  * ACC_W'(red);
         cr_g_ff <= COEF_CR_G * ACC_W'(green);
         cr_b_ff <= COEF_CR_B * ACC_W'(blue);
      end
   end

   // Sums wrap modulo 2^ACC_W, which keeps exactly the low eight bits of the result.
   always_comb begin
      y_sum_in  = BIAS_Y + HALF + y_r_ff + y_g_ff + y_b_ff;
      cb_sum_in = BIAS_C + HALF + cb_b_ff - cb_r_ff - cb_g_ff;
      cr_sum_in = BIAS_C + HALF + cr_r_ff - cr_g_ff - cr_b_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         luma_ff <= y_sum_in[ACC_W-1:FRAC_BITS];
         cb_ff   <= cb_sum_in[ACC_W-1:FRAC_BITS];
         cr_ff   <= cr_sum_in[ACC_W-1:FRAC_BITS];
      end
   end

   assign luma = luma_ff;
   assign cb   = cb_ff;
   assign cr   = cr_ff;

endmodule

// ----- rtl/ycc420_merge.sv -----
// Merging stage: reduces the four chroma pairs by mode and holds the output register.
module ycc420_merge import ycc420_pkg::*; (
   input  logic                clock,
   input  logic                load,
   input  chroma_mode_type     mode,
   input  sample_set_type      luma_in,
   input  sample_set_type      cb_in,
   input  sample_set_type      cr_in,
   output sample_set_type      luma_out,
   output logic [SAMPLE_W-1:0] cb_out,
   output logic [SAMPLE_W-1:0] cr_out
);

   logic [SAMPLE_W+1:0] cb_total, cr_total;
   logic [SAMPLE_W-1:0] cb_in_sel, cr_in_sel;
   sample_set_type      luma_ff;
   logic [SAMPLE_W-1:0] cb_ff, cr_ff;

   always_comb begin
      cb_total = (SAMPLE_W+2)'(cb_in[0]) + (SAMPLE_W+2)'(cb_in[1])
               + (SAMPLE_W+2)'(cb_in[2]) + (SAMPLE_W+2)'(cb_in[3]) + (SAMPLE_W+2)'(2);
      cr_total = (SAMPLE_W+2)'(cr_in[0]) + (SAMPLE_W+2)'(cr_in[1])
               + (SAMPLE_W+2)'(cr_in[2]) + (SAMPLE_W+2)'(cr_in[3]) + (SAMPLE_W+2)'(2);
      unique case (mode)
         CHROMA_TOP_LEFT: begin
            cb_in_sel = cb_in[0];
            cr_in_sel = cr_in[0];
         end
         CHROMA_MEAN: begin
            cb_in_sel = cb_total[SAMPLE_W+1:2];
            cr_in_sel = cr_total[SAMPLE_W+1:2];
         end
         default: begin
            cb_in_sel = '0;
            cr_in_sel = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         luma_ff <= luma_in;
         cb_ff   <= cb_in_sel;
         cr_ff   <= cr_in_sel;
      end
   end

   assign luma_out = luma_ff;
   assign cb_out   = cb_ff;
   assign cr_out   = cr_ff;

endmodule

// ----- rtl/rgb_to_ycbcr_420_block.sv -----
// Top level of the 2x2 RGB to YCbCr 4:2:0 converter with its register port.
//
// A request carries one 2x2 block of 8-bit RGB pixels on the req_ channel.
// The rsp_ channel returns four luma samples and one Cb and one Cr sample.
// Both channels use valid and ready; a transfer happens when both are high.
// Four pixel lanes each compute products in one stage and sums in the next.
// The merging stage then reduces chroma and loads the output register.
// Throughput is one block per cycle while the receiver keeps rsp_ready high; the pipeline has three stages.
// Each stage advances when the stage after it is empty or is moving on.
// When the receiver stalls, requests keep entering until every stage is full.
// The chroma_mode register sits at address 0 of the APB port, reset value 2.
// Reset empties the pipeline and restores chroma_mode to its reset value.
module rgb_to_ycbcr_420_block import ycc420_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_red_00,
   input  logic [SAMPLE_W-1:0]   req_green_00,
   input  logic [SAMPLE_W-1:0]   req_blue_00,
   input  logic [SAMPLE_W-1:0]   req_red_01,
   input  logic [SAMPLE_W-1:0]   req_green_01,
   input  logic [SAMPLE_W-1:0]   req_blue_01,
   input  logic [SAMPLE_W-1:0]   req_red_10,
   input  logic [SAMPLE_W-1:0]   req_green_10,
   input  logic [SAMPLE_W-1:0]   req_blue_10,
   input  logic [SAMPLE_W-1:0]   req_red_11,
   input  logic [SAMPLE_W-1:0]   req_green_11,
   input  logic [SAMPLE_W-1:0]   req_blue_11,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SAMPLE_W-1:0]   rsp_luma_00,
   output logic [SAMPLE_W-1:0]   rsp_luma_01,
   output logic [SAMPLE_W-1:0]   rsp_luma_10,
   output logic [SAMPLE_W-1:0]   rsp_luma_11,
   output logic [SAMPLE_W-1:0]   rsp_blue_chroma,
   output logic [SAMPLE_W-1:0]   rsp_red_chroma,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   chroma_mode_type chroma_mode_ff, chroma_mode_in;
   logic            prod_valid_ff, prod_valid_in;
   logic            sum_valid_ff, sum_valid_in;
   logic            out_valid_ff, out_valid_in;
   logic            out_load, sum_load, prod_load;
   lane_ctrl_type   lane_ctrl;
   sample_set_type  pix_red, pix_green, pix_blue;
   sample_set_type  lane_luma, lane_cb, lane_cr, out_luma;

   assign pready = 1'b1;
   assign prdata = CSR_DATA_W'(chroma_mode_ff);

   always_comb begin
      chroma_mode_in = chroma_mode_ff;
      if (psel && penable && pwrite && pready && (paddr == CSR_CHROMA_MODE_ADDR)) begin
         chroma_mode_in = chroma_mode_type'(pwdata[1:0]);
      end
   end

   always_comb begin
      out_load  = !out_valid_ff || rsp_ready;
      sum_load  = !sum_valid_ff || out_load;
      prod_load = !prod_valid_ff || sum_load;
      req_ready = prod_load;
      prod_valid_in = prod_load ? req_valid : prod_valid_ff;
      sum_valid_in  = sum_load ? prod_valid_ff : sum_valid_ff;
      out_valid_in  = out_load ? sum_valid_ff : out_valid_ff;
      lane_ctrl.prod_en = prod_load;
      lane_ctrl.sum_en  = sum_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chroma_mode_ff <= CHROMA_MEAN;
         prod_valid_ff  <= 1'b0;
         sum_valid_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         chroma_mode_ff <= chroma_mode_in;
         prod_valid_ff  <= prod_valid_in;
         sum_valid_ff   <= sum_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   assign pix_red   = {req_red_11, req_red_10, req_red_01, req_red_00};
   assign pix_green = {req_green_11, req_green_10, req_green_01, req_green_00};
   assign pix_blue  = {req_blue_11, req_blue_10, req_blue_01, req_blue_00};

   for (genvar lane = 0; lane < PIXEL_COUNT; lane++) begin : g_lane
      ycc420_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .ctrl  (lane_ctrl),
         .red   (pix_red[lane]),
         .green (pix_green[lane]),
         .blue  (pix_blue[lane]),
         .luma  (lane_luma[lane]),
         .cb    (lane_cb[lane]),
         .cr    (lane_cr[lane])
      );
   end

   ycc420_merge u_merge (
      .clock    (clock),
      .load     (out_load),
      .mode     (chroma_mode_ff),
      .luma_in  (lane_luma),
      .cb_in    (lane_cb),
      .cr_in    (lane_cr),
      .luma_out (out_luma),
      .cb_out   (rsp_blue_chroma),
      .cr_out   (rsp_red_chroma)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_luma_00 = out_luma[0];
   assign rsp_luma_01 = out_luma[1];
   assign rsp_luma_10 = out_luma[2];
   assign rsp_luma_11 = out_luma[3];

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("Request channel stalled while the output register was empty.");

   a_accept_fills_lanes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> prod_valid_ff)
      else $error("Accepted request did not enter the product stage.");

   a_result_from_sum_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(sum_valid_ff))
      else $error("Result appeared without a block in the sum stage.");

endmodule

// ----- dv/tb_rgb_to_ycbcr_420_block.sv -----
// Testbench for the 2x2 RGB to YCbCr 4:2:0 converter with a built-in predictor.
`timescale 1ns / 1ps

module tb_rgb_to_ycbcr_420_block;
   import ycc420_pkg::*;

   localparam int     F           = FRAC_BITS_DEFAULT;
   localparam longint K_Y_RED     = ((longint'(257) << F) + 500) / 1000;
   localparam longint K_Y_GREEN   = ((longint'(504) << F) + 500) / 1000;
   localparam longint K_Y_BLUE    = ((longint'(98) << F) + 500) / 1000;
   localparam longint K_CB_RED    = ((longint'(148) << F) + 500) / 1000;
   localparam longint K_CB_GREEN  = ((longint'(291) << F) + 500) / 1000;
   localparam longint K_CB_BLUE   = ((longint'(439) << F) + 500) / 1000;
   localparam longint K_CR_RED    = ((longint'(439) << F) + 500) / 1000;
   localparam longint K_CR_GREEN  = ((longint'(368) << F) + 500) / 1000;
   localparam longint K_CR_BLUE   = ((longint'(71) << F) + 500) / 1000;
   localparam int     PHASES      = 8;
   localparam int     PHASE_ITEMS = 225;
   localparam int     HOLD_CYCLES = 300;
   localparam int     MAX_REPORTS = 10;

   // Index 0 is the top-left pixel, 1 top-right, 2 bottom-left, 3 bottom-right.
   typedef struct packed {
      logic [3:0][7:0] red;
      logic [3:0][7:0] green;
      logic [3:0][7:0] blue;
   } rgb_block_type;

   typedef struct packed {
      logic [3:0][7:0] luma;
      logic [7:0]      cb;
      logic [7:0]      cr;
   } ycc_result_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   rgb_block_type   drv_blk = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   ycc_result_type  got;
   logic            psel = 1'b0;
   logic            penable = 1'b0;
   logic            pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = CSR_CHROMA_MODE_ADDR;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic            pready;

   rgb_block_type   pending_blocks[$];
   ycc_result_type  expected_results[$];
   ycc_result_type  want;
   chroma_mode_type chroma_setting = CHROMA_MEAN;
   int              mismatches = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   int              holds_asked = 0;
   int              holds_begun = 0;
   int              hold_left = 0;

   rgb_to_ycbcr_420_block u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_00      (drv_blk.red[0]),
      .req_green_00    (drv_blk.green[0]),
      .req_blue_00     (drv_blk.blue[0]),
      .req_red_01      (drv_blk.red[1]),
      .req_green_01    (drv_blk.green[1]),
      .req_blue_01     (drv_blk.blue[1]),
      .req_red_10      (drv_blk.red[2]),
      .req_green_10    (drv_blk.green[2]),
      .req_blue_10     (drv_blk.blue[2]),
      .req_red_11      (drv_blk.red[3]),
      .req_green_11    (drv_blk.green[3]),
      .req_blue_11     (drv_blk.blue[3]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_luma_00     (got.luma[0]),
      .rsp_luma_01     (got.luma[1]),
      .rsp_luma_10     (got.luma[2]),
      .rsp_luma_11     (got.luma[3]),
      .rsp_blue_chroma (got.cb),
      .rsp_red_chroma  (got.cr),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_rgb_to_ycbcr_420_block: FAIL");
      $finish;
   end

   // Rounds a fixed-point sum to an integer sample and keeps the low byte.
   function automatic logic [7:0] round_sample(longint acc);
      longint v;
      v = (acc + (longint'(256) << F) + (longint'(1) << (F - 1))) >>> F;
      return v[7:0];
   endfunction

   function automatic ycc_result_type convert_block(rgb_block_type blk, chroma_mode_type mode);
      longint         r;
      longint         g;
      longint         b;
      logic [7:0]     cb_pix[4];
      logic [7:0]     cr_pix[4];
      int             cb_sum;
      int             cr_sum;
      ycc_result_type res;
      cb_sum = 0;
      cr_sum = 0;
      for (int p = 0; p < 4; p++) begin
         r = longint'(blk.red[p]);
         g = longint'(blk.green[p]);
         b = longint'(blk.blue[p]);
         res.luma[p] = round_sample((longint'(16) << F) + K_Y_RED * r + K_Y_GREEN * g
                                    + K_Y_BLUE * b);
         cb_pix[p] = round_sample((longint'(128) << F) - K_CB_RED * r - K_CB_GREEN * g
                                  + K_CB_BLUE * b);
         cr_pix[p] = round_sample((longint'(128) << F) + K_CR_RED * r - K_CR_GREEN * g
                                  - K_CR_BLUE * b);
         cb_sum += cb_pix[p];
         cr_sum += cr_pix[p];
      end
      case (mode)
         CHROMA_TOP_LEFT: begin
            res.cb = cb_pix[0];
            res.cr = cr_pix[0];
         end
         CHROMA_MEAN: begin
            res.cb = 8'((cb_sum + 2) >> 2);
            res.cr = 8'((cr_sum + 2) >> 2);
         end
         default: begin
            res.cb = '0;
            res.cr = '0;
         end
      endcase
      return res;
   endfunction

   function automatic rgb_block_type uniform_block(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rgb_block_type blk;
      for (int p = 0; p < 4; p++) begin
         blk.red[p]   = r;
         blk.green[p] = g;
         blk.blue[p]  = b;
      end
      return blk;
   endfunction

   function automatic logic [7:0] rand_level();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report(string what, ycc_result_type exp_res, ycc_result_type act_res);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t %s: expected luma %h %h %h %h cb %h cr %h, got luma %h %h %h %h cb %h cr %h",
                  $realtime, what,
                  exp_res.luma[0], exp_res.luma[1], exp_res.luma[2], exp_res.luma[3],
                  exp_res.cb, exp_res.cr,
                  act_res.luma[0], act_res.luma[1], act_res.luma[2], act_res.luma[3],
                  act_res.cb, act_res.cr);
      end
   endtask

   // One APB transfer to the chroma_mode register; a read is checked against the setting.
   task automatic csr_transfer(bit is_write, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CSR_CHROMA_MODE_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (is_write) begin
         chroma_setting = chroma_mode_type'(value[1:0]);
      end else if (prdata[1:0] !== chroma_setting) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t chroma_mode readback: expected %0d, got %0d",
                     $realtime, chroma_setting, prdata[1:0]);
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_blocks.size() != 0 || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // Request driver: the head of pending_blocks is offered until it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(convert_block(drv_blk, chroma_setting));
            void'(pending_blocks.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (pending_blocks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drv_blk   <= pending_blocks[0];
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness, including the long hold-off that backs up the pipeline.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_begun != holds_asked) begin
         rsp_ready   <= 1'b0;
         hold_left   <= HOLD_CYCLES;
         holds_begun <= holds_begun + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report("unexpected result", '0, got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               report("result mismatch", want, got);
            end
         end
      end
   end

   initial begin
      chroma_mode_type mode_plan[PHASES];
      int              send_plan[4];
      int              stall_plan[4];
      rgb_block_type   blk;
      logic [31:0]     word;
      mode_plan  = '{CHROMA_ZERO, CHROMA_TOP_LEFT, CHROMA_ZERO_ALT, CHROMA_MEAN,
                     CHROMA_TOP_LEFT, CHROMA_ZERO, CHROMA_MEAN, CHROMA_ZERO_ALT};
      send_plan  = '{0, 70, 0, 22};
      stall_plan = '{0, 0, 70, 22};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      csr_transfer(1'b0, '0);

      pending_blocks.push_back(uniform_block(8'h00, 8'h00, 8'h00));
      pending_blocks.push_back(uniform_block(8'hFF, 8'hFF, 8'hFF));
      pending_blocks.push_back(uniform_block(8'hFF, 8'h00, 8'h00));
      pending_blocks.push_back(uniform_block(8'h00, 8'hFF, 8'h00));
      pending_blocks.push_back(uniform_block(8'h00, 8'h00, 8'hFF));
      pending_blocks.push_back(uniform_block(8'h00, 8'hFF, 8'hFF));
      pending_blocks.push_back(uniform_block(8'hFF, 8'h00, 8'hFF));
      pending_blocks.push_back(uniform_block(8'hFF, 8'hFF, 8'h00));
      pending_blocks.push_back(uniform_block(8'hAA, 8'h55, 8'hAA));
      pending_blocks.push_back(uniform_block(8'h55, 8'hAA, 8'h55));
      for (int k = 0; k < 8; k++) begin
         pending_blocks.push_back(uniform_block(8'(1 << k), 8'(1 << k), 8'(1 << k)));
      end
      // Each pixel gets a different color so that a swapped lane shows up.
      blk = uniform_block(8'h00, 8'h00, 8'h00);
      blk.red[0]   = 8'hFF;
      blk.green[1] = 8'hFF;
      blk.blue[2]  = 8'hFF;
      blk.red[3]   = 8'hFF;
      blk.green[3] = 8'hFF;
      blk.blue[3]  = 8'hFF;
      pending_blocks.push_back(blk);
      for (int p = 0; p < 4; p++) begin
         blk.red[p]   = 8'(p * 63 + 3);
         blk.green[p] = 8'(250 - p * 61);
         blk.blue[p]  = 8'(p * 37 + 101);
      end
      pending_blocks.push_back(blk);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         word      = $urandom();
         word[1:0] = mode_plan[phase];
         csr_transfer(1'b1, word);
         csr_transfer(1'b0, '0);
         send_idle_pct  = send_plan[phase % 4];
         recv_stall_pct = stall_plan[phase % 4];
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            for (int p = 0; p < 4; p++) begin
               blk.red[p]   = rand_level();
               blk.green[p] = rand_level();
               blk.blue[p]  = rand_level();
            end
            pending_blocks.push_back(blk);
         end
         if (phase == 4) begin
            holds_asked++;
         end
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("tb_rgb_to_ycbcr_420_block: PASS");
      end else begin
         $display("tb_rgb_to_ycbcr_420_block: FAIL");
      end
      $finish;
   end

endmodule
